// ===== rtl/core/pitc_pkg.sv =====
`default_nettype none
package pitc_pkg;

  localparam int COORD_W     = 11;
  localparam int DIFF_W      = 12;
  localparam int CFG_IDX_W   = 3;
  localparam int OUT_CNT_W   = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int IN_DATA_W   = 24;
  localparam int OUT_DATA_W  = 24;

  localparam int OUTER_COORD_DEF = 1200;
  localparam int COUNT_WIDTH_DEF = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_A_X = 3'd0,
    REG_A_Y = 3'd1,
    REG_B_X = 3'd2,
    REG_B_Y = 3'd3,
    REG_C_X = 3'd4,
    REG_C_Y = 3'd5
  } cfg_reg_t;

  // one triangle side against the point: w = q - p, e = side direction
  typedef struct packed {
    logic signed [DIFF_W-1:0] wx;
    logic signed [DIFF_W-1:0] wy;
    logic signed [DIFF_W-1:0] ex;
    logic signed [DIFF_W-1:0] ey;
  } side_t;

  typedef struct packed {
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    logic               vertex_hit;
    logic               last;
    side_t [2:0]        side;
  } point_rec_t;

endpackage
`default_nettype wire

// ===== rtl/core/point_in_triangle_counter.sv =====
// Channel | Dir | tdata (low bit up)                 | tlast
// in_     | in  | point_x[10:0], point_y[21:11]       | last_point
// out_    | out | inside_res[0], inside_count[16:1]  | set_done
// cfg_    | in  | cfg_index selects vertex register, cfg_wdata holds coordinate
//
// One point per cycle sustained while the output is not stalled; each point
// passes through input register, queue, ray stage, product stage,
// crossing stage and output register. No clearing pass after reset.
// Either side may stall; the four-entry queue absorbs back-end stalls.
`default_nettype none
module point_in_triangle_counter #(
  parameter int OUTER_COORD = pitc_pkg::OUTER_COORD_DEF,
  parameter int COUNT_WIDTH = pitc_pkg::COUNT_WIDTH_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 cfg_we,
  input  wire  [pitc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [pitc_pkg::COORD_W-1:0]        cfg_wdata,
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  input  wire  [pitc_pkg::IN_DATA_W-1:0]      in_tdata,  // point_x, point_y
  input  wire                                 in_tlast,
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  output logic [pitc_pkg::OUT_DATA_W-1:0]     out_tdata, // inside_res, inside_count
  output logic                                out_tlast
);

  logic                           f_valid, f_ready;
  pitc_pkg::point_rec_t           f_rec;
  logic                           q_valid, q_ready;
  pitc_pkg::point_rec_t           q_rec;
  logic                           res_inside;
  logic [pitc_pkg::OUT_CNT_W-1:0] res_count;

  pitc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .pt_x      (in_tdata[pitc_pkg::COORD_W-1:0]),
    .pt_y      (in_tdata[2*pitc_pkg::COORD_W-1:pitc_pkg::COORD_W]),
    .pt_last   (in_tlast),
    .rec_valid (f_valid),
    .rec_ready (f_ready),
    .rec       (f_rec)
  );

  pitc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_rec),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_rec)
  );

  pitc_back #(
    .OUTER_COORD (OUTER_COORD),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .rec_valid  (q_valid),
    .rec_ready  (q_ready),
    .rec        (q_rec),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .res_inside (res_inside),
    .res_count  (res_count),
    .res_last   (out_tlast)
  );

  assign out_tdata = {
    (pitc_pkg::OUT_DATA_W - pitc_pkg::OUT_CNT_W - 1)'(0),
    res_count,
    res_inside
  };

endmodule
`default_nettype wire

// ===== rtl/core/pitc_front.sv =====
`default_nettype none
module pitc_front (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 cfg_we,
  input  wire  [pitc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [pitc_pkg::COORD_W-1:0]        cfg_wdata,
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  input  wire  [pitc_pkg::COORD_W-1:0]        pt_x,
  input  wire  [pitc_pkg::COORD_W-1:0]        pt_y,
  input  wire                                 pt_last,
  output logic                                rec_valid,
  input  wire                                 rec_ready,
  output pitc_pkg::point_rec_t                rec
);

  logic [pitc_pkg::COORD_W-1:0] ax_r, ay_r, bx_r, by_r, cx_r, cy_r;
  logic                         fv_r;
  pitc_pkg::point_rec_t         rec_r, rec_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ax_r <= '0; ay_r <= '0;
      bx_r <= '0; by_r <= '0;
      cx_r <= '0; cy_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        pitc_pkg::REG_A_X: ax_r <= cfg_wdata;
        pitc_pkg::REG_A_Y: ay_r <= cfg_wdata;
        pitc_pkg::REG_B_X: bx_r <= cfg_wdata;
        pitc_pkg::REG_B_Y: by_r <= cfg_wdata;
        pitc_pkg::REG_C_X: cx_r <= cfg_wdata;
        pitc_pkg::REG_C_Y: cy_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  function automatic logic signed [pitc_pkg::DIFF_W-1:0] sdiff(
    input logic [pitc_pkg::COORD_W-1:0] a,
    input logic [pitc_pkg::COORD_W-1:0] b
  );
    sdiff = $signed({1'b0, a}) - $signed({1'b0, b});
  endfunction

  always_comb begin
    rec_nxt.px = pt_x;
    rec_nxt.py = pt_y;
    rec_nxt.last = pt_last;
    rec_nxt.vertex_hit = (pt_x == ax_r && pt_y == ay_r) ||
                         (pt_x == bx_r && pt_y == by_r) ||
                         (pt_x == cx_r && pt_y == cy_r);
    // side A-B from B
    rec_nxt.side[0].wx = sdiff(bx_r, pt_x);
    rec_nxt.side[0].wy = sdiff(by_r, pt_y);
    rec_nxt.side[0].ex = sdiff(ax_r, bx_r);
    rec_nxt.side[0].ey = sdiff(ay_r, by_r);
    // side A-C from C
    rec_nxt.side[1].wx = sdiff(cx_r, pt_x);
    rec_nxt.side[1].wy = sdiff(cy_r, pt_y);
    rec_nxt.side[1].ex = sdiff(ax_r, cx_r);
    rec_nxt.side[1].ey = sdiff(ay_r, cy_r);
    // side B-C from C
    rec_nxt.side[2].wx = sdiff(cx_r, pt_x);
    rec_nxt.side[2].wy = sdiff(cy_r, pt_y);
    rec_nxt.side[2].ex = sdiff(bx_r, cx_r);
    rec_nxt.side[2].ey = sdiff(by_r, cy_r);
  end

  assign in_tready = !fv_r || rec_ready;
  assign rec_valid = fv_r;
  assign rec       = rec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else if (in_tready) begin
      fv_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      rec_r <= rec_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/pitc_queue.sv =====
`default_nettype none
module pitc_queue (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    wr_valid,
  output logic                   wr_ready,
  input  pitc_pkg::point_rec_t   wr_data,
  output logic                   rd_valid,
  input  wire                    rd_ready,
  output pitc_pkg::point_rec_t   rd_data
);

  localparam int AW = $clog2(pitc_pkg::QUEUE_DEPTH);

  pitc_pkg::point_rec_t mem_r [pitc_pkg::QUEUE_DEPTH];
  logic [AW-1:0]        wr_ptr_r, rd_ptr_r;
  logic [AW:0]          fill_r;
  logic                 push, pop;

  assign wr_ready = (fill_r != (AW+1)'(pitc_pkg::QUEUE_DEPTH));
  assign rd_valid = (fill_r != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        fill_r <= fill_r + 1'b1;
      end else if (pop && !push) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/pitc_back.sv =====
`default_nettype none
module pitc_back #(
  parameter int OUTER_COORD = pitc_pkg::OUTER_COORD_DEF,
  parameter int COUNT_WIDTH = pitc_pkg::COUNT_WIDTH_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              rec_valid,
  output logic                             rec_ready,
  input  pitc_pkg::point_rec_t             rec,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic                             res_inside,
  output logic [pitc_pkg::OUT_CNT_W-1:0]   res_count,
  output logic                             res_last
);

  localparam int DW0 = $clog2(OUTER_COORD + 1) + 1;
  localparam int DW  = (DW0 > pitc_pkg::DIFF_W) ? DW0 : pitc_pkg::DIFF_W;
  localparam int PW  = DW + pitc_pkg::DIFF_W;
  localparam int SW  = PW + 1;

  typedef struct packed {
    logic signed [PW-1:0] den_a, den_b;
    logic signed [PW-1:0] n1_a, n1_b;
    logic signed [PW-1:0] n2_a, n2_b;
  } prod_t;

  // stage 1: ray direction
  logic                     v1_r;
  logic signed [DW-1:0]     dx_r, dy_r;
  pitc_pkg::point_rec_t     rec1_r;
  // stage 2: products
  logic                     v2_r;
  prod_t [2:0]              prod_r, prod_nxt;
  logic                     vh2_r, last2_r;
  // stage 3: crossings
  logic                     v3_r;
  logic [2:0]               cross_r, cross_nxt;
  logic                     vh3_r, last3_r;
  // output
  logic                     vo_r;
  logic                     inside_r;
  logic [pitc_pkg::OUT_CNT_W-1:0] cnt_out_r;
  logic                     last_o_r;
  logic [COUNT_WIDTH-1:0]   cnt_r, cnt_nxt;
  logic                     inside_nxt;

  logic ld_o, ld3, ld2, ld1;

  assign ld_o = !vo_r || out_ready;
  assign ld3  = !v3_r || ld_o;
  assign ld2  = !v2_r || ld3;
  assign ld1  = !v1_r || ld2;
  assign rec_ready = ld1;

  function automatic logic in_unit(input logic signed [SW-1:0] num,
                                   input logic signed [SW-1:0] den);
    if (den > 0) begin
      in_unit = (num >= 0) && (num <= den);
    end else begin
      in_unit = (num <= 0) && (num >= den);
    end
  endfunction

  always_comb begin
    for (int s = 0; s < 3; s++) begin
      prod_nxt[s].den_a = PW'(dx_r) * PW'(rec1_r.side[s].ey);
      prod_nxt[s].den_b = PW'(dy_r) * PW'(rec1_r.side[s].ex);
      prod_nxt[s].n1_a  = PW'(rec1_r.side[s].wx) * PW'(rec1_r.side[s].ey);
      prod_nxt[s].n1_b  = PW'(rec1_r.side[s].wy) * PW'(rec1_r.side[s].ex);
      prod_nxt[s].n2_a  = PW'(rec1_r.side[s].wx) * PW'(dy_r);
      prod_nxt[s].n2_b  = PW'(rec1_r.side[s].wy) * PW'(dx_r);
    end
  end

  always_comb begin
    logic signed [SW-1:0] den, n1, n2;
    for (int s = 0; s < 3; s++) begin
      den = SW'(prod_r[s].den_a) - SW'(prod_r[s].den_b);
      n1  = SW'(prod_r[s].n1_a) - SW'(prod_r[s].n1_b);
      n2  = SW'(prod_r[s].n2_a) - SW'(prod_r[s].n2_b);
      cross_nxt[s] = (den != 0) && in_unit(n1, den) && in_unit(n2, den);
    end
  end

  always_comb begin
    inside_nxt = vh3_r || cross_r == 3'b001 || cross_r == 3'b010 ||
                 cross_r == 3'b100;
    cnt_nxt = cnt_r;
    if (inside_nxt && cnt_r != '1) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      vo_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (ld1) begin
        v1_r <= rec_valid;
      end
      if (ld2) begin
        v2_r <= v1_r;
      end
      if (ld3) begin
        v3_r <= v2_r;
      end
      if (ld_o) begin
        vo_r <= v3_r;
        if (v3_r) begin
          cnt_r <= last3_r ? '0 : cnt_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld1 && rec_valid) begin
      rec1_r <= rec;
      dx_r   <= $signed(DW'(OUTER_COORD)) - $signed(DW'(rec.px));
      dy_r   <= $signed(DW'(OUTER_COORD)) - $signed(DW'(rec.py));
    end
    if (ld2 && v1_r) begin
      prod_r  <= prod_nxt;
      vh2_r   <= rec1_r.vertex_hit;
      last2_r <= rec1_r.last;
    end
    if (ld3 && v2_r) begin
      cross_r <= cross_nxt;
      vh3_r   <= vh2_r;
      last3_r <= last2_r;
    end
    if (ld_o && v3_r) begin
      inside_r  <= inside_nxt;
      cnt_out_r <= pitc_pkg::OUT_CNT_W'(cnt_nxt);
      last_o_r  <= last3_r;
    end
  end

  assign out_valid  = vo_r;
  assign res_inside = inside_r;
  assign res_count  = cnt_out_r;
  assign res_last   = last_o_r;

endmodule
`default_nettype wire
